// File: hdl/stx_lrc_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// stx_lrc_frame_receiver_assert.svh
// Assertion macros for the frame receiver parser.
// ----------------------------------------------------------------------------
`ifndef STX_LRC_FRAME_RECEIVER_ASSERT_SVH
`define STX_LRC_FRAME_RECEIVER_ASSERT_SVH

// Concurrent assertion on a given clock, masked while reset is low
`define STXLRC_ASSERT_CLK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset
`define STXLRC_ASSERT(lbl, prop, msg) \
	`STXLRC_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// File: hdl/stxlrc_pkg.sv
// ----------------------------------------------------------------------------
// stxlrc_pkg
// Types, codes and reset values of the LRC frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package stxlrc_pkg;

	// Field widths
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned BUDGET_W  = 16;
	localparam int unsigned MAXLEN_W  = 9;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ATTEMPTS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME      = 2'd2;

	// Register reset values
	localparam logic [BYTE_W-1:0]   RST_START_BYTE     = 8'd2;
	localparam logic [BUDGET_W-1:0] RST_START_ATTEMPTS = 16'd10;
	localparam logic [MAXLEN_W-1:0] RST_MAX_FRAME      = 9'd257;

	// Seed of the running XOR
	localparam logic [BYTE_W-1:0] LRC_SEED = 8'h00;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_CMD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LEN    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd3;

	// Frame status codes
	localparam logic [STATUS_W-1:0] ST_GOOD    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BADLRC  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOSTART = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOOLONG = 3'd4;

	// Receiver phase
	typedef enum logic [2:0] {
		PH_HUNT,
		PH_CMD,
		PH_LEN,
		PH_DATA,
		PH_LRC
	} phase_t;

	// One received item
	typedef struct packed {
		logic              is_timeout;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	// One result item
	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic [KIND_W-1:0]   byte_kind;
		logic                frame_end;
		logic [STATUS_W-1:0] status;
	} res_t;

	// Configuration register contents
	typedef struct packed {
		logic [BYTE_W-1:0]   start_byte;
		logic [BUDGET_W-1:0] start_attempts;
		logic [MAXLEN_W-1:0] max_frame_bytes;
	} cfg_t;

	// Budget rewrite event
	typedef struct packed {
		logic                load;
		logic [BUDGET_W-1:0] value;
	} budget_t;

endpackage

`default_nettype wire

// File: hdl/stxlrc_if.sv
// ----------------------------------------------------------------------------
// stxlrc_if
// Valid/ready channels of the LRC frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

// Received bytes and read timeouts
interface stxlrc_in_if;
	import stxlrc_pkg::*;
	logic              valid;
	logic              ready;
	logic              is_timeout;
	logic [BYTE_W-1:0] rx_byte;
	modport source (output valid, output is_timeout, output rx_byte, input ready);
	modport sink (input valid, input is_timeout, input rx_byte, output ready);
endinterface

// Frame bytes and status results
interface stxlrc_out_if;
	import stxlrc_pkg::*;
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic [KIND_W-1:0]   byte_kind;
	logic                frame_end;
	logic [STATUS_W-1:0] status;
	modport source (output valid, output out_byte, output byte_kind, output frame_end,
		output status, input ready);
	modport sink (input valid, input out_byte, input byte_kind, input frame_end,
		input status, output ready);
endinterface

// Register writes
interface stxlrc_cfg_if;
	import stxlrc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/stxlrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// stxlrc_cfg_regs
// Configuration registers; flags a start budget rewrite to the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module stxlrc_cfg_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	stxlrc_cfg_if.sink             cfg,
	output stxlrc_pkg::cfg_t       cfg_q,
	output stxlrc_pkg::budget_t    budget
);
	import stxlrc_pkg::*;

	logic wr;

	// Always take writes
	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	// Update the addressed register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte      <= RST_START_BYTE;
			cfg_q.start_attempts  <= RST_START_ATTEMPTS;
			cfg_q.max_frame_bytes <= RST_MAX_FRAME;
		end else if (wr) begin
			case (cfg.index)
				CFG_START_BYTE: begin
					cfg_q.start_byte <= cfg.data[BYTE_W-1:0];
				end
				CFG_START_ATTEMPTS: begin
					cfg_q.start_attempts <= cfg.data[BUDGET_W-1:0];
				end
				CFG_MAX_FRAME: begin
					cfg_q.max_frame_bytes <= cfg.data[MAXLEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Budget rewrite goes straight to the parser
	assign budget.load  = wr && (cfg.index == CFG_START_ATTEMPTS);
	assign budget.value = cfg.data[BUDGET_W-1:0];

endmodule

`default_nettype wire

// File: hdl/stxlrc_in_stage.sv
// ----------------------------------------------------------------------------
// stxlrc_in_stage
// Input register: holds one received item until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module stxlrc_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	stxlrc_in_if.sink          rx,
	input  wire logic          step,
	output logic               valid_s1,
	output stxlrc_pkg::item_t  item_s1
);
	import stxlrc_pkg::*;

	logic take;

	// Accept when empty or when the held item moves on this cycle
	assign rx.ready = !valid_s1 || step;
	assign take     = rx.valid && rx.ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Load payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.is_timeout <= rx.is_timeout;
			item_s1.rx_byte    <= rx.rx_byte;
		end
	end

endmodule

`default_nettype wire

// File: hdl/stxlrc_parser.sv
// ----------------------------------------------------------------------------
// stxlrc_parser
// Frame state machine: start hunt, command, length, data and LRC check.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stx_lrc_frame_receiver_assert.svh"

module stxlrc_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire stxlrc_pkg::item_t    item_s1,
	input  wire stxlrc_pkg::cfg_t     cfg_q,
	input  wire stxlrc_pkg::budget_t  budget,
	output logic                      res_valid,
	output stxlrc_pkg::res_t          res_c
);
	import stxlrc_pkg::*;

	phase_t                phase_q, phase_d;
	logic [BYTE_W-1:0]     xor_q, xor_d;
	logic [BYTE_W-1:0]     left_q, left_d;
	logic [BUDGET_W-1:0]   attempts_q, attempts_d;
	logic                  tmo;
	logic [BYTE_W-1:0]     b;
	logic                  is_start;
	logic                  too_long;
	logic [MAXLEN_W-1:0]   len_plus2;
	logic [BYTE_W-1:0]     left_dec;

	assign tmo       = item_s1.is_timeout;
	assign b         = item_s1.rx_byte;
	assign is_start  = !tmo && (b == cfg_q.start_byte);
	assign len_plus2 = {1'b0, b} + MAXLEN_W'(2);
	assign too_long  = len_plus2 > cfg_q.max_frame_bytes;
	assign left_dec  = (left_q != '0) ? left_q - BYTE_W'(1) : left_q;

	// Next state
	always_comb begin
		phase_d    = phase_q;
		xor_d      = xor_q;
		left_d     = left_q;
		attempts_d = attempts_q;
		if (step) begin
			case (phase_q)
				PH_HUNT: begin
					if (is_start) begin
						phase_d = PH_CMD;
						xor_d   = LRC_SEED;
						left_d  = '0;
					end else if (attempts_q <= BUDGET_W'(1)) begin
						attempts_d = cfg_q.start_attempts;
					end else begin
						attempts_d = attempts_q - BUDGET_W'(1);
					end
				end
				PH_CMD: begin
					if (tmo) begin
						phase_d    = PH_HUNT;
						left_d     = '0;
						attempts_d = cfg_q.start_attempts;
					end else begin
						phase_d = PH_LEN;
						xor_d   = LRC_SEED ^ b;
					end
				end
				PH_LEN: begin
					if (tmo || too_long) begin
						phase_d    = PH_HUNT;
						left_d     = '0;
						attempts_d = cfg_q.start_attempts;
					end else begin
						xor_d   = xor_q ^ b;
						left_d  = b;
						phase_d = (b != '0) ? PH_DATA : PH_LRC;
					end
				end
				PH_DATA: begin
					if (tmo) begin
						phase_d    = PH_HUNT;
						left_d     = '0;
						attempts_d = cfg_q.start_attempts;
					end else begin
						xor_d  = xor_q ^ b;
						left_d = left_dec;
						if (left_dec == '0) begin
							phase_d = PH_LRC;
						end
					end
				end
				PH_LRC: begin
					phase_d    = PH_HUNT;
					left_d     = '0;
					attempts_d = cfg_q.start_attempts;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
		// Rewrite of the budget reloads it while hunting
		if (budget.load && (phase_q == PH_HUNT)) begin
			attempts_d = budget.value;
		end
	end

	// Result of the item now in the input register
	always_comb begin
		res_valid       = 1'b0;
		res_c.out_byte  = '0;
		res_c.byte_kind = KIND_STATUS;
		res_c.frame_end = 1'b1;
		res_c.status    = ST_GOOD;
		case (phase_q)
			PH_HUNT: begin
				res_valid    = !is_start && (attempts_q <= BUDGET_W'(1));
				res_c.status = ST_NOSTART;
			end
			PH_CMD: begin
				res_valid = 1'b1;
				if (tmo) begin
					res_c.status = ST_TIMEOUT;
				end else begin
					res_c.out_byte  = b;
					res_c.byte_kind = KIND_CMD;
					res_c.frame_end = 1'b0;
				end
			end
			PH_LEN: begin
				res_valid = 1'b1;
				if (tmo) begin
					res_c.status = ST_TIMEOUT;
				end else if (too_long) begin
					res_c.status = ST_TOOLONG;
				end else begin
					res_c.out_byte  = b;
					res_c.byte_kind = KIND_LEN;
					res_c.frame_end = 1'b0;
				end
			end
			PH_DATA: begin
				res_valid = 1'b1;
				if (tmo) begin
					res_c.status = ST_TIMEOUT;
				end else begin
					res_c.out_byte  = b;
					res_c.byte_kind = KIND_DATA;
					res_c.frame_end = 1'b0;
				end
			end
			PH_LRC: begin
				res_valid = 1'b1;
				if (tmo) begin
					res_c.status = ST_TIMEOUT;
				end else begin
					res_c.status = (b == xor_q) ? ST_GOOD : ST_BADLRC;
				end
			end
			default: begin
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			xor_q      <= LRC_SEED;
			left_q     <= '0;
			attempts_q <= RST_START_ATTEMPTS;
		end else begin
			phase_q    <= phase_d;
			xor_q      <= xor_d;
			left_q     <= left_d;
			attempts_q <= attempts_d;
		end
	end

	// Any frame-ending result sends the parser back to hunting
	`STXLRC_ASSERT(a_end_to_hunt, (step && res_valid && res_c.frame_end) |=> (phase_q == PH_HUNT), "frame end did not return to hunt")
	// Data phase always has bytes still to come
	`STXLRC_ASSERT(a_data_left, (phase_q == PH_DATA) |-> (left_q != '0), "data phase with no bytes left")
	// Leaving hunt takes a start byte and gives no result
	`STXLRC_ASSERT(a_start_silent, (step && (phase_q == PH_HUNT) && (phase_d == PH_CMD)) |-> (is_start && !res_valid), "hunt left without a silent start byte")

endmodule

`default_nettype wire

// File: hdl/stxlrc_out_stage.sv
// ----------------------------------------------------------------------------
// stxlrc_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module stxlrc_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              res_valid,
	input  wire stxlrc_pkg::res_t  res_c,
	output logic                   room,
	stxlrc_out_if.source           res
);
	import stxlrc_pkg::*;

	logic   valid_s2;
	res_t   res_s2;

	// Room for a new result when empty or when the held one leaves now
	assign room = !valid_s2 || res.ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= res_valid;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Load payload
	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_s2 <= res_c;
		end
	end

	assign res.valid     = valid_s2;
	assign res.out_byte  = res_s2.out_byte;
	assign res.byte_kind = res_s2.byte_kind;
	assign res.frame_end = res_s2.frame_end;
	assign res.status    = res_s2.status;

endmodule

`default_nettype wire

// File: hdl/stx_lrc_frame_receiver.sv
// ----------------------------------------------------------------------------
// stx_lrc_frame_receiver
// Receiver for START, COMMAND, LENGTH, data, LRC frames with status results.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                   Taken when
//   rx       in   is_timeout, rx_byte                       rx.valid & rx.ready
//   res      out  out_byte, byte_kind, frame_end, status    res.valid & res.ready
//   cfg      in   index, data                               cfg.valid (ready is 1)
//
// One item per cycle unless the result register stalls: an item waits in the input
// register, the frame state machine decodes it and any result lands in the result
// register. A stalled result register holds the input register, which then holds
// rx.ready low. arst_n clears the registers to their defaults and the parser to
// hunting with a budget of ten.
//
`default_nettype none

module stx_lrc_frame_receiver (
	input  wire logic     clk,
	input  wire logic     arst_n,
	stxlrc_in_if.sink     rx,
	stxlrc_out_if.source  res,
	stxlrc_cfg_if.sink    cfg
);
	import stxlrc_pkg::*;

	cfg_t     cfg_q;
	budget_t  budget;
	logic     valid_s1;
	item_t    item_s1;
	logic     step;
	logic     room;
	logic     res_valid;
	res_t     res_c;

	// Advance the held item when the result register has room
	assign step = valid_s1 && room;

	stxlrc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q),
		.budget (budget)
	);

	stxlrc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.step     (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	stxlrc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item_s1   (item_s1),
		.cfg_q     (cfg_q),
		.budget    (budget),
		.res_valid (res_valid),
		.res_c     (res_c)
	);

	stxlrc_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res_c     (res_c),
		.room      (room),
		.res       (res)
	);

endmodule

`default_nettype wire

// File: test/stx_lrc_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// stx_lrc_frame_receiver_tb
// Self-checking bench for the LRC frame receiver. Received bytes and read
// timeouts go in over the rx channel; a tracker of the parser state works out
// every frame byte and status the block must hand out, and each result is
// compared field by field, in order. A directed pass hits field extremes,
// every timeout point, the start budget and the length limit; random frame
// traffic then runs under a series of register settings with random idling
// on both channels, and a final stretch runs with no idling at all.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_lrc_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stxlrc_pkg::*;

	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam int ITEM_TARGET  = 1350;
	localparam int NUM_PHASES   = 12;
	localparam int BURST_MAX    = 18;
	localparam int SETTLE_TICKS = 6;
	localparam int QUIET_LIMIT  = 1000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	stxlrc_in_if  rx_ch ();
	stxlrc_out_if res_ch ();
	stxlrc_cfg_if cfg_ch ();

	stx_lrc_frame_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// Tracked registers and parser state
	cfg_t                regs;
	phase_t              parse_phase;
	logic [BYTE_W-1:0]   lrc_acc;
	logic [BYTE_W-1:0]   data_left;
	logic [BUDGET_W-1:0] budget_left;

	// Frame bytes and statuses still owed by the block, oldest first
	res_t frame_out_due[$];

	int mismatches = 0;
	int items_sent = 0;
	int tx_run     = 0;
	int ready_hold = 0;
	int quiet_ticks = 0;
	bit calm       = 1'b0;

	// ------------------------------------------------------------------
	// Parser tracking
	// ------------------------------------------------------------------

	function automatic void reset_tracker();
		regs        = cfg_t'{RST_START_BYTE, RST_START_ATTEMPTS, RST_MAX_FRAME};
		parse_phase = PH_HUNT;
		lrc_acc     = '0;
		data_left   = '0;
		budget_left = RST_START_ATTEMPTS;
	endfunction

	// End the frame attempt with a status and go back to hunting
	function automatic void close_frame(input logic [STATUS_W-1:0] st);
		frame_out_due.push_back(res_t'{8'h00, KIND_STATUS, 1'b1, st});
		parse_phase = PH_HUNT;
		data_left   = '0;
		budget_left = regs.start_attempts;
	endfunction

	function automatic void pass_byte(input logic [BYTE_W-1:0] b, input logic [KIND_W-1:0] k);
		frame_out_due.push_back(res_t'{b, k, 1'b0, '0});
	endfunction

	function automatic void parse_rx(input item_t it);
		logic [BYTE_W-1:0] b;
		b = it.rx_byte;
		case (parse_phase)
			PH_CMD: begin
				if (it.is_timeout) begin
					close_frame(ST_TIMEOUT);
				end else begin
					lrc_acc     = LRC_SEED ^ b;
					parse_phase = PH_LEN;
					pass_byte(b, KIND_CMD);
				end
			end
			PH_LEN: begin
				if (it.is_timeout) begin
					close_frame(ST_TIMEOUT);
				end else if (int'(b) + 2 > int'(regs.max_frame_bytes)) begin
					close_frame(ST_TOOLONG);
				end else begin
					lrc_acc   = lrc_acc ^ b;
					data_left = b;
					if (b != 0) parse_phase = PH_DATA;
					else parse_phase = PH_LRC;
					pass_byte(b, KIND_LEN);
				end
			end
			PH_DATA: begin
				if (it.is_timeout) begin
					close_frame(ST_TIMEOUT);
				end else begin
					lrc_acc = lrc_acc ^ b;
					if (data_left > 0) data_left = data_left - 1'b1;
					if (data_left == 0) parse_phase = PH_LRC;
					pass_byte(b, KIND_DATA);
				end
			end
			PH_LRC: begin
				if (it.is_timeout) close_frame(ST_TIMEOUT);
				else if (b == lrc_acc) close_frame(ST_GOOD);
				else close_frame(ST_BADLRC);
			end
			default: begin
				if (!it.is_timeout && b == regs.start_byte) begin
					parse_phase = PH_CMD;
					lrc_acc     = LRC_SEED;
					data_left   = '0;
				end else if (budget_left <= 1) begin
					close_frame(ST_NOSTART);
				end else begin
					budget_left = budget_left - 1'b1;
				end
			end
		endcase
	endfunction

	// A budget write while hunting reloads the count at once
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] value);
		case (idx)
			CFG_START_BYTE: regs.start_byte = value[BYTE_W-1:0];
			CFG_START_ATTEMPTS: begin
				regs.start_attempts = value;
				if (parse_phase == PH_HUNT) budget_left = value;
			end
			CFG_MAX_FRAME: regs.max_frame_bytes = value[MAXLEN_W-1:0];
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 200)
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// Compare each accepted result with the oldest one owed
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (frame_out_due.size() == 0) begin
				mismatches++;
				$display("%0t: result expected none actual byte %0h kind %0d end %0b status %0d",
					$time, res_ch.out_byte, res_ch.byte_kind, res_ch.frame_end,
					res_ch.status);
			end else begin
				want = frame_out_due.pop_front();
				compare_field("out_byte", 32'(want.out_byte), 32'(res_ch.out_byte));
				compare_field("byte_kind", 32'(want.byte_kind), 32'(res_ch.byte_kind));
				compare_field("frame_end", 32'(want.frame_end), 32'(res_ch.frame_end));
				compare_field("status", 32'(want.status), 32'(res_ch.status));
			end
		end
	end

	// Stall the result channel in random bursts, never once calm; hold low in reset
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (calm) begin
			res_ch.ready <= 1'b1;
		end else if (ready_hold != 0) begin
			ready_hold--;
		end else if ($urandom_range(0, 1) == 0) begin
			res_ch.ready <= 1'b0;
			ready_hold = $urandom_range(0, BURST_MAX - 1);
		end else begin
			res_ch.ready <= 1'b1;
			ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(0, 30);
		end
	end

	// Count cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_ticks <= 0;
		end else if (quiet_ticks >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_ticks <= quiet_ticks + 1;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one item, with a random gap ahead of it unless calm
	task automatic send_item(input item_t it);
		if (!calm && tx_run == 0) begin
			if ($urandom_range(0, 1) == 0) begin
				rx_ch.valid <= 1'b0;
				repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
			end
			tx_run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 30);
		end
		if (tx_run > 0) tx_run--;
		rx_ch.valid      <= 1'b1;
		rx_ch.is_timeout <= it.is_timeout;
		rx_ch.rx_byte    <= it.rx_byte;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		parse_rx(it);
		items_sent++;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_item(item_t'{1'b0, b});
	endtask

	task automatic send_timeout();
		send_item(item_t'{1'b1, 8'($urandom)});
	endtask

	// Hold off input until every owed result is out and the pipe is empty
	task automatic settle_block();
		rx_ch.valid <= 1'b0;
		while (frame_out_due.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Leaves valid high so back-to-back writes follow without a gap
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		apply_reg(idx, value);
	endtask

	// Noise, then a frame with random content; some get a bad LRC, some a
	// timeout in place of one of their items, some a length over the limit
	task automatic send_frame_attempt();
		int noise, len, cut, limit, k;
		logic [BYTE_W-1:0] b, lrc;
		noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : $urandom_range(0, 2);
		repeat (noise) begin
			if ($urandom_range(0, 4) == 0) begin
				b = ($urandom_range(0, 2) == 0) ? regs.start_byte : 8'($urandom);
				send_item(item_t'{1'b1, b});
			end else begin
				b = 8'($urandom);
				if (b == regs.start_byte) b = ~b;
				send_byte(b);
			end
		end
		limit = int'(regs.max_frame_bytes);
		case ($urandom_range(0, 59))
			0: len = $urandom_range(7, 255);
			1, 2, 3, 4: len = (limit < 2) ? 0 : limit - 2 + $urandom_range(0, 1);
			default: len = $urandom_range(0, 6);
		endcase
		if (len > 255) len = 255;
		// Item positions: 0 command, 1 length, then data, last the LRC
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len + 2) : -1;
		send_byte(regs.start_byte);
		lrc = LRC_SEED;
		for (k = 0; k <= len + 2; k++) begin
			if (k == cut) begin
				send_timeout();
				return;
			end
			if (k == len + 2) begin
				b = ($urandom_range(0, 7) == 0) ? lrc ^ 8'($urandom_range(1, 255)) : lrc;
			end else begin
				b = (k == 1) ? 8'(len) : 8'($urandom);
				lrc = lrc ^ b;
			end
			send_byte(b);
			if (k == 1 && len + 2 > limit) return;
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_frame_fields();
		// Good frame with extreme command and data bytes
		send_byte(RST_START_BYTE);
		send_byte(8'hFF);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h02);
		// Zero length, then a timeout where the LRC belongs
		send_byte(RST_START_BYTE);
		send_byte(8'h00);
		send_byte(8'h00);
		send_timeout();
		// Timeout at command, at length and inside data
		send_byte(RST_START_BYTE);
		send_timeout();
		send_byte(RST_START_BYTE);
		send_byte(8'h11);
		send_timeout();
		send_byte(RST_START_BYTE);
		send_byte(8'h11);
		send_byte(8'h01);
		send_timeout();
	endtask

	task automatic test_start_budget();
		// Zero budget acts as one attempt
		settle_block();
		set_reg(CFG_START_ATTEMPTS, 16'd0);
		cfg_ch.valid <= 1'b0;
		send_byte(8'h55);
		// Rewrite while hunting reloads a partly spent budget
		settle_block();
		set_reg(CFG_START_ATTEMPTS, 16'd2);
		cfg_ch.valid <= 1'b0;
		send_byte(8'h55);
		settle_block();
		set_reg(CFG_START_ATTEMPTS, 16'd2);
		cfg_ch.valid <= 1'b0;
		send_byte(8'h55);
		send_byte(8'h55);
		// Rewrite inside a frame takes effect when the frame ends; the
		// unused index must leave every register alone
		send_byte(RST_START_BYTE);
		settle_block();
		set_reg(CFG_START_ATTEMPTS, 16'd3);
		set_reg(CFG_UNUSED, 16'h0001);
		cfg_ch.valid <= 1'b0;
		send_timeout();
		send_byte(8'h55);
		send_timeout();
		send_byte(8'h55);
	endtask

	task automatic test_length_limit();
		// A limit of one rejects even a zero length frame
		settle_block();
		set_reg(CFG_MAX_FRAME, 16'd1);
		cfg_ch.valid <= 1'b0;
		send_byte(RST_START_BYTE);
		send_byte(8'h00);
		send_byte(8'h00);
		// A limit of two fits zero length only
		settle_block();
		set_reg(CFG_MAX_FRAME, 16'd2);
		cfg_ch.valid <= 1'b0;
		send_byte(RST_START_BYTE);
		send_byte(8'h07);
		send_byte(8'h00);
		send_byte(8'h07);
		send_byte(RST_START_BYTE);
		send_byte(8'h07);
		send_byte(8'h01);
	endtask

	task automatic test_random_traffic();
		int p, first, phase_end;
		logic [BYTE_W-1:0] sb;
		logic [BUDGET_W-1:0] tries;
		logic [CFG_DAT_W-1:0] maxf;
		first = items_sent;
		for (p = 0; p < NUM_PHASES - 1; p++) begin
			settle_block();
			case ($urandom_range(0, 3))
				0: sb = 8'h00;
				1: sb = 8'hFF;
				default: sb = 8'($urandom);
			endcase
			case ($urandom_range(0, 6))
				0: tries = 16'd0;
				1: tries = 16'd1;
				2: tries = 16'd2;
				3: tries = 16'hFFFF;
				4: tries = RST_START_ATTEMPTS;
				default: tries = 16'($urandom_range(3, 20));
			endcase
			case ($urandom_range(0, 7))
				0: maxf = 16'd0;
				1: maxf = 16'd1;
				2: maxf = 16'd2;
				3: maxf = 16'd257;
				4: maxf = 16'd511;
				5: maxf = 16'($urandom);
				default: maxf = 16'($urandom_range(3, 40));
			endcase
			// Pin the extremes on the first two settings
			if (p == 0) begin
				sb    = 8'h00;
				tries = 16'd1;
				maxf  = 16'd2;
			end else if (p == 1) begin
				sb    = 8'hFF;
				tries = 16'hFFFF;
				maxf  = 16'd257;
			end
			set_reg(CFG_START_BYTE, {8'($urandom), sb});
			set_reg(CFG_START_ATTEMPTS, tries);
			set_reg(CFG_MAX_FRAME, maxf);
			cfg_ch.valid <= 1'b0;
			phase_end = first + (p + 1) * ITEM_TARGET / NUM_PHASES;
			while (items_sent < phase_end) send_frame_attempt();
		end
	endtask

	// Last stretch at full rate on reset settings
	task automatic test_calm_traffic();
		int stop_at;
		settle_block();
		calm <= 1'b1;
		set_reg(CFG_START_BYTE, 16'(RST_START_BYTE));
		set_reg(CFG_START_ATTEMPTS, RST_START_ATTEMPTS);
		set_reg(CFG_MAX_FRAME, 16'(RST_MAX_FRAME));
		cfg_ch.valid <= 1'b0;
		stop_at = items_sent + ITEM_TARGET / NUM_PHASES;
		while (items_sent < stop_at) send_frame_attempt();
	endtask

	initial begin
		rx_ch.valid      <= 1'b0;
		rx_ch.is_timeout <= 1'b0;
		rx_ch.rx_byte    <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= '0;
		cfg_ch.data      <= '0;
		reset_tracker();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_frame_fields();
		test_start_budget();
		test_length_limit();
		test_random_traffic();
		test_calm_traffic();
		settle_block();

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
